// ===== rtl/icy_pkg.sv =====
// Shared constants, types and codes for the ICY metadata demultiplexer.
package icy_pkg;

  localparam int unsigned INTERVAL_BITS   = 24;
  localparam int unsigned BYTE_BITS       = 8;
  localparam int unsigned META_UNIT_SHIFT = 4;
  localparam int unsigned META_LEFT_BITS  = BYTE_BITS + META_UNIT_SHIFT;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_TEXT  = 2'd1,
    KIND_PAD   = 2'd2,
    KIND_LEN   = 2'd3
  } byte_kind_e;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    byte_kind_e           byte_kind;
    logic                 block_last;
  } result_t;

endpackage

// ===== rtl/icy_byte_if.sv =====
// Input byte channel: valid/ready handshake carrying one stream byte.
interface icy_byte_if;
  logic                           valid;
  logic                           ready;
  logic [icy_pkg::BYTE_BITS-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/icy_result_if.sv =====
// Result channel: valid/ready handshake carrying a tagged byte.
interface icy_result_if;
  logic                           valid;
  logic                           ready;
  logic [icy_pkg::BYTE_BITS-1:0]  out_byte;
  logic [1:0]                     byte_kind;
  logic                           block_last;

  modport source (output valid, output out_byte, output byte_kind, output block_last,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input block_last,
                  output ready);
endinterface

// ===== rtl/icy_cfg_if.sv =====
// Configuration write channel: valid/ready handshake carrying the interval.
interface icy_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [icy_pkg::INTERVAL_BITS-1:0]  meta_interval;

  modport source (output valid, output meta_interval, input ready);
  modport sink   (input valid, input meta_interval, output ready);
endinterface

// ===== rtl/icy_framer.sv =====
// Input register, framing counters and byte classification.
module icy_framer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [icy_pkg::INTERVAL_BITS-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  input  logic [icy_pkg::BYTE_BITS-1:0]     in_byte_i,
  output logic                              in_ready_o,
  output logic                              res_valid_o,
  output icy_pkg::result_t                  res_o,
  input  logic                              res_ready_i
);

  logic                                   in_valid_q;
  logic [icy_pkg::BYTE_BITS-1:0]          in_byte_q;
  logic [icy_pkg::INTERVAL_BITS-1:0]      interval_q;
  logic [icy_pkg::INTERVAL_BITS-1:0]      audio_left_q, audio_left_d;
  logic [icy_pkg::META_LEFT_BITS-1:0]     meta_left_q, meta_left_d;
  logic                                   zero_seen_q, zero_seen_d;
  logic [icy_pkg::META_LEFT_BITS-1:0]     meta_len;
  logic [icy_pkg::META_LEFT_BITS-1:0]     meta_dec;
  logic                                   advance;
  icy_pkg::byte_kind_e                    kind;
  logic                                   last;

  assign advance    = in_valid_q && res_ready_i;
  assign in_ready_o = !in_valid_q || res_ready_i;
  assign meta_len   = {in_byte_q, {icy_pkg::META_UNIT_SHIFT{1'b0}}};
  assign meta_dec   = meta_left_q - {{(icy_pkg::META_LEFT_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    kind         = icy_pkg::KIND_AUDIO;
    last         = 1'b0;
    audio_left_d = audio_left_q;
    meta_left_d  = meta_left_q;
    zero_seen_d  = zero_seen_q;
    if (interval_q == '0 || audio_left_q != '0) begin
      if (interval_q != '0) begin
        audio_left_d = audio_left_q - {{(icy_pkg::INTERVAL_BITS-1){1'b0}}, 1'b1};
      end
    end else if (meta_left_q == '0) begin
      // length byte; zero length closes an empty block at once
      kind        = icy_pkg::KIND_LEN;
      meta_left_d = meta_len;
      zero_seen_d = 1'b0;
      if (meta_len == '0) begin
        last         = 1'b1;
        audio_left_d = interval_q;
      end
    end else begin
      if (zero_seen_q || in_byte_q == '0) begin
        zero_seen_d = 1'b1;
        kind        = icy_pkg::KIND_PAD;
      end else begin
        kind = icy_pkg::KIND_TEXT;
      end
      meta_left_d = meta_dec;
      if (meta_dec == '0) begin
        last         = 1'b1;
        audio_left_d = interval_q;
        zero_seen_d  = 1'b0;
      end
    end
  end

  assign res_valid_o      = in_valid_q;
  assign res_o.out_byte   = in_byte_q;
  assign res_o.byte_kind  = kind;
  assign res_o.block_last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      interval_q   <= '0;
      audio_left_q <= '0;
      meta_left_q  <= '0;
      zero_seen_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (cfg_valid_i) begin
        interval_q   <= cfg_data_i;
        audio_left_q <= cfg_data_i;
        meta_left_q  <= '0;
        zero_seen_q  <= 1'b0;
      end else if (advance) begin
        audio_left_q <= audio_left_d;
        meta_left_q  <= meta_left_d;
        zero_seen_q  <= zero_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

endmodule

// ===== rtl/icy_out_reg.sv =====
// Result register between the classifier and the output channel.
module icy_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  icy_pkg::result_t res_i,
  output logic             res_ready_o,
  output logic             out_valid_o,
  output icy_pkg::result_t out_o,
  input  logic             out_ready_i
);

  logic             valid_q;
  icy_pkg::result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

endmodule

// ===== rtl/icy_metadata_demux.sv =====
// Top level of the ICY in-band metadata demultiplexer.
// Pipeline: input register, then result register, between input and result accept.
// Throughput: one item per cycle while the sink keeps taking results; the framing
// counters update in a single pass per byte.
// Reset (rst_ni, asynchronous, active low): interval zero, so every byte is audio;
// counters and the zero-seen flag cleared, both pipeline stages empty.
// Configuration writes are always accepted and restart framing from a full interval.
module icy_metadata_demux (
  input  logic                clk_i,
  input  logic                rst_ni,
  icy_cfg_if.sink             cfg_i,
  icy_byte_if.sink            in_i,
  icy_result_if.source        out_o
);

  // classifier to result register
  logic             res_valid;
  logic             res_ready;
  icy_pkg::result_t res;
  icy_pkg::result_t out_data;

  // the interval register takes a write on any cycle
  assign cfg_i.ready = 1'b1;

  // input register plus counters; an item moves on whenever the result
  // register has room, so one more item can wait here while a result is held
  icy_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.meta_interval),
    .in_valid_i  (in_i.valid),
    .in_byte_i   (in_i.in_byte),
    .in_ready_o  (in_i.ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // result register holds each tagged byte until the sink takes it
  icy_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (out_o.valid),
    .out_o       (out_data),
    .out_ready_i (out_o.ready)
  );

  assign out_o.out_byte   = out_data.out_byte;
  assign out_o.byte_kind  = out_data.byte_kind;
  assign out_o.block_last = out_data.block_last;

  // an audio byte never closes a metadata block
  a_last_not_audio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.block_last |-> out_o.byte_kind != icy_pkg::KIND_AUDIO)
    else $error("block end flagged on an audio byte");

  // input stalls only when both stages are full and the sink is holding off
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready && res_valid)
    else $error("input stalled without downstream back-pressure");

  // a length byte of zero must close the (empty) block on the same item
  a_empty_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.byte_kind == icy_pkg::KIND_LEN && out_o.out_byte == '0
    |-> out_o.block_last)
    else $error("zero length byte did not end the block");

endmodule

// ===== dv/icy_metadata_demux_test.sv =====
// Self-checking testbench for the ICY metadata demultiplexer: directed cases, random streams.
module icy_metadata_demux_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [icy_pkg::INTERVAL_BITS-1:0]  interval_t;
  typedef logic [icy_pkg::BYTE_BITS-1:0]      byte_t;
  typedef logic [icy_pkg::META_LEFT_BITS-1:0] meta_count_t;

  // The watchdog gives up after this many cycles in which no channel moves an item.
  // Longest legal quiet spell: the receiver hold (HOLD_CYCLES) plus a drain pause, well below this.
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned MAX_REPORTS     = 10;
  // Two-stage pipeline; spare cycles after the last result catch stray items.
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam interval_t   INTERVAL_MAX    = '1;
  // Bytes of a length-255 block sent before the next interval write cuts it short.
  localparam int unsigned LONG_BLOCK_PART = 120;
  localparam int unsigned PHASE_ITEMS     = 50;

  logic clk;
  logic rst_n;

  icy_cfg_if    cfg_if ();
  icy_byte_if   in_if ();
  icy_result_if out_if ();

  icy_metadata_demux dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Framing state as the testbench sees it; follows accepted items and interval writes.
  interval_t   interval_q;
  interval_t   audio_left;
  meta_count_t meta_left;
  logic        zero_seen;

  icy_pkg::result_t expected_tags[$];
  int unsigned      err_count    = 0;
  int unsigned      stall_cycles = 0;
  int unsigned      rx_hold      = 0;
  bit               tx_gaps      = 1'b1;
  bit               rx_gaps      = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle gap length: mostly none or short, now and then long.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void restart_framing(input interval_t interval);
    interval_q = interval;
    audio_left = interval;
    meta_left  = '0;
    zero_seen  = 1'b0;
  endfunction

  // Tags one stream byte and advances the framing state.
  function automatic icy_pkg::result_t tag_byte(input byte_t b);
    icy_pkg::result_t r;
    r.out_byte   = b;
    r.byte_kind  = icy_pkg::KIND_AUDIO;
    r.block_last = 1'b0;
    if (interval_q == '0 || audio_left != '0) begin
      // audio; with interval zero the counters stand still
      if (interval_q != '0) audio_left = audio_left - interval_t'(1);
    end else if (meta_left == '0) begin
      // length byte, read unsigned; zero closes an empty block at once
      r.byte_kind = icy_pkg::KIND_LEN;
      meta_left   = {b, {icy_pkg::META_UNIT_SHIFT{1'b0}}};
      zero_seen   = 1'b0;
      if (b == '0) begin
        r.block_last = 1'b1;
        audio_left   = interval_q;
      end
    end else begin
      // metadata: text until the first zero, padding from the zero on
      if (zero_seen || b == '0) begin
        zero_seen   = 1'b1;
        r.byte_kind = icy_pkg::KIND_PAD;
      end else begin
        r.byte_kind = icy_pkg::KIND_TEXT;
      end
      meta_left = meta_left - meta_count_t'(1);
      if (meta_left == '0) begin
        r.block_last = 1'b1;
        audio_left   = interval_q;
        zero_seen    = 1'b0;
      end
    end
    return r;
  endfunction

  // Picks a byte that suits the next position of the frame, so that most streams run
  // through whole blocks: short lengths, empty blocks, zeros scattered in the text.
  function automatic byte_t next_stream_byte();
    int unsigned r;
    if (interval_q != '0 && audio_left == '0) begin
      if (meta_left == '0) begin
        r = $urandom_range(0, 99);
        if (r < 25) return 8'h00;
        if (r < 80) return byte_t'($urandom_range(1, 2));
        if (r < 97) return byte_t'($urandom_range(3, 6));
        return byte_t'($urandom_range(7, 20));
      end
      if ($urandom_range(0, 7) == 0) return 8'h00;
    end
    return byte_t'($urandom);
  endfunction

  // Offers one item until it is taken, then records its tag and maybe idles.
  task automatic send_byte(input byte_t b);
    int unsigned gap;
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    expected_tags.push_back(tag_byte(b));
    gap = tx_gaps ? idle_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits for every tag to come back, plus a spare drain pause.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The interval is only written once the pipeline has drained, possibly mid-block.
  task automatic write_interval(input interval_t interval);
    wait_drained();
    cfg_if.valid         <= 1'b1;
    cfg_if.meta_interval <= interval;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    restart_framing(interval);
  endtask

  task automatic note_mismatch(input string field, input byte_t want, input byte_t got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  // Straight after reset the interval is zero, so everything is audio.
  task automatic test_reset_state();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h01);
  endtask

  // One-byte interval: empty block, then a 16-byte block with text, a zero and padding.
  task automatic test_framing_cases();
    write_interval(interval_t'(1));
    send_byte(8'h80);
    send_byte(8'h00);  // empty block
    send_byte(8'h7F);
    send_byte(8'h01);  // one unit of metadata
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(8'h80);
    send_byte(8'h00);  // first zero, padding from here on
    repeat (11) send_byte(byte_t'($urandom_range(1, 255)));  // nonzero padding
    send_byte(8'h00);  // closes the block
    send_byte(8'hC3);
  endtask

  // Interval at both ends of its range.
  task automatic test_interval_extremes();
    write_interval(INTERVAL_MAX);
    repeat (20) send_byte(byte_t'($urandom));
    write_interval('0);
    repeat (10) send_byte(byte_t'($urandom));
  endtask

  // A write in the middle of a block drops what is left of it.
  task automatic test_restart_mid_block();
    write_interval(interval_t'(2));
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h02);
    repeat (7) send_byte(byte_t'($urandom_range(1, 255)));
    write_interval(interval_t'(3));
    repeat (3) send_byte(byte_t'($urandom));
    send_byte(8'h00);
  endtask

  // Length byte 255: the widest count, with a zero partway in; the next interval write
  // cuts the block short. No idling here.
  task automatic test_longest_block();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_interval(interval_t'(1));
    send_byte(byte_t'($urandom));
    send_byte(8'hFF);
    for (int unsigned i = 0; i < LONG_BLOCK_PART; i++) begin
      send_byte((i == LONG_BLOCK_PART / 2) ? 8'h00 : byte_t'($urandom_range(1, 255)));
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Receiver holds off for a long stretch while items keep coming: the block fills and stalls.
  task automatic test_backpressure();
    write_interval(interval_t'(3));
    tx_gaps = 1'b0;
    rx_hold = HOLD_CYCLES;
    repeat (60) send_byte(next_stream_byte());
    tx_gaps = 1'b1;
  endtask

  // Random streams over a run of intervals, with idling switched on and off per phase.
  task automatic test_random_streams();
    interval_t interval;
    for (int unsigned phase = 0; phase < 12; phase++) begin
      case (phase % 6)
        0: interval = interval_t'(1);
        1: interval = interval_t'(2);
        2: interval = interval_t'($urandom_range(3, 8));
        3: interval = interval_t'(16);
        4: interval = interval_t'($urandom_range(1, 64));
        default: interval = (phase == 5) ? '0 : interval_t'($urandom_range(1, 4));
      endcase
      write_interval(interval);
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_byte(next_stream_byte());
    end
  endtask

  // Result checker: each item taken off the output against the oldest tag.
  always @(posedge clk) begin : check_results
    icy_pkg::result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_tags.size() == 0) begin
        note_mismatch("unexpected item, out_byte", 8'h00, out_if.out_byte);
      end else begin
        want = expected_tags.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          note_mismatch("out_byte", want.out_byte, out_if.out_byte);
        end
        if (out_if.byte_kind !== want.byte_kind) begin
          note_mismatch("byte_kind", byte_t'(want.byte_kind), byte_t'(out_if.byte_kind));
        end
        if (out_if.block_last !== want.block_last) begin
          note_mismatch("block_last", byte_t'(want.block_last), byte_t'(out_if.block_last));
        end
      end
    end
  end

  // Receiver: a long hold when asked, otherwise ready with random stalls.
  initial begin : receiver
    int unsigned stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold != 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else if (stall != 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (rx_gaps && $urandom_range(0, 3) == 0) stall = idle_gap();
      end
    end
  end

  // Watchdog: too long with no item moving on any channel ends the run.
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : main
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.in_byte        <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.meta_interval <= '0;
    restart_framing('0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_framing_cases();
    test_interval_extremes();
    test_restart_mid_block();
    test_longest_block();
    test_backpressure();
    test_random_streams();

    wait_drained();
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/icy_pkg.sv
rtl/icy_byte_if.sv
rtl/icy_result_if.sv
rtl/icy_cfg_if.sv
rtl/icy_framer.sv
rtl/icy_out_reg.sv
rtl/icy_metadata_demux.sv
dv/icy_metadata_demux_test.sv
